// ===== rtl/ihc_pkg.sv =====
`default_nettype none
package ihc_pkg;

    localparam int IN_TDATA_W  = 32;
    localparam int OUT_TDATA_W = 72;

    typedef enum logic [2:0] {
        ST_OK             = 3'd0,
        ST_TRUNCATED      = 3'd1,
        ST_NOT_IPV4       = 3'd2,
        ST_BAD_HLEN       = 3'd3,
        ST_LEN_OVER_CAP   = 3'd4,
        ST_LEN_UNDER_HLEN = 3'd5,
        ST_MULTI_ENCAP    = 3'd6
    } status_t;

    localparam logic [15:0] MIN_HDR_BYTES = 16'd20;
    localparam logic [3:0]  IP_VERSION4   = 4'd4;
    localparam logic [7:0]  PROTO_UDP     = 8'd17;

    // header byte positions
    localparam logic [5:0] POS_VER_IHL  = 6'd0;
    localparam logic [5:0] POS_TOTLEN_H = 6'd2;
    localparam logic [5:0] POS_TOTLEN_L = 6'd3;
    localparam logic [5:0] POS_FRAG_H   = 6'd6;
    localparam logic [5:0] POS_FRAG_L   = 6'd7;
    localparam logic [5:0] POS_PROTO    = 6'd9;
    localparam logic [5:0] POS_SRC_0    = 6'd12;
    localparam logic [5:0] POS_SRC_1    = 6'd13;
    localparam logic [5:0] POS_SRC_2    = 6'd14;
    localparam logic [5:0] POS_SRC_3    = 6'd15;
    localparam logic [5:0] POS_DST_0    = 6'd16;
    localparam logic [5:0] POS_DST_1    = 6'd17;
    localparam logic [5:0] POS_DST_2    = 6'd18;
    localparam logic [5:0] POS_DST_3    = 6'd19;

    // warning bit indexes
    localparam int W_SAME_ADDR   = 0;
    localparam int W_SRC_BCAST   = 1;
    localparam int W_DST_BCAST   = 2;
    localparam int W_LOOPBACK    = 3;
    localparam int W_SRC_THISNET = 4;
    localparam int W_DST_THISNET = 5;
    localparam int W_SRC_MCAST   = 6;
    localparam int W_SRC_RSVD    = 7;
    localparam int W_DST_RSVD    = 8;
    localparam int W_DF_OFFSET   = 9;
    localparam int W_LEN_OFFSET  = 10;
    localparam int W_ZERO_FRAG   = 11;
    localparam int W_BAD_FRAGBIT = 12;
    localparam int W_BAD_CSUM    = 13;

    typedef struct packed {
        status_t     status;
        logic        raise_event;
        logic [5:0]  hdr_bytes;
        logic [15:0] total_len;
        logic [15:0] frag_word;
        logic [7:0]  proto;
        logic [31:0] src_addr;
        logic [31:0] dst_addr;
        logic [20:0] sum;
    } hdr_info_t;

    typedef struct packed {
        status_t     status;
        logic        raise_error_event;
        logic [13:0] warning_flags;
        logic [5:0]  header_len;
        logic [15:0] payload_len;
        logic [7:0]  next_protocol;
        logic        hand_to_next_layer;
        logic        is_fragment;
        logic [12:0] frag_ofs;
        logic        more_fragments;
        logic        dont_fragment;
        logic        reserved_flag;
    } result_t;

endpackage
`default_nettype wire

// ===== rtl/ipv4_header_checker_top.sv =====
// IPv4 header checker.
// s_ channel: one header byte per word, in network order. s_tuser marks the
// first byte of a header; that word also carries the captured length and the
// encapsulation flags, which are ignored on later words.
// m_ channel: at most one result word per header, either a rejection
// (status and event only, raised at byte 0 or byte 3) or the decoded header
// with its warning flags after the last header byte (IHL*4 bytes).
// cfg_wr_en / cfg_wr_data write check_checksum (1 after reset); write it
// only while no header is in flight.
// Throughput: one byte per cycle while s_tready is high; headers need no gap.
// Path: the result of the deciding byte passes the byte parser register and
// then the check/output register on its way to m_.
// Reset: the parser waits for a first byte, both result registers are empty.
// Stall: a result holds on m_ while m_tready is low; bytes that give no result
// keep flowing, and s_tready drops only once both result registers are full.
`default_nettype none
module ipv4_header_checker_top (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire logic                             cfg_wr_en,
    input  wire logic                             cfg_wr_data,
    input  wire logic                             s_tvalid,
    output logic                                  s_tready,
    // data_byte, captured_length, after_ip_layer, already_tunneled, unsure_encap
    input  wire logic [ihc_pkg::IN_TDATA_W-1:0]   s_tdata,
    // first_byte
    input  wire logic                             s_tuser,
    output logic                                  m_tvalid,
    input  wire logic                             m_tready,
    // status, raise_error_event, warning_flags, header_len, payload_len,
    // next_protocol, hand_to_next_layer, is_fragment, frag_ofs,
    // more_fragments, dont_fragment, reserved_flag
    output logic [ihc_pkg::OUT_TDATA_W-1:0]       m_tdata
);
    import ihc_pkg::*;

    logic      check_checksum_reg, check_checksum_next;
    logic      mid_valid, mid_ready;
    hdr_info_t mid_info;
    result_t   res;

    always_comb begin
        check_checksum_next = cfg_wr_en ? cfg_wr_data : check_checksum_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            check_checksum_reg <= 1'b1;
        end else begin
            check_checksum_reg <= check_checksum_next;
        end
    end

    ihc_parse u_parse (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .in_valid         (s_tvalid),
        .in_ready         (s_tready),
        .data_byte        (s_tdata[7:0]),
        .first_byte       (s_tuser),
        .captured_length  (s_tdata[23:8]),
        .after_ip_layer   (s_tdata[24]),
        .already_tunneled (s_tdata[25]),
        .unsure_encap     (s_tdata[26]),
        .out_valid        (mid_valid),
        .out_ready        (mid_ready),
        .out_info         (mid_info)
    );

    ihc_check u_check (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .check_checksum (check_checksum_reg),
        .in_valid       (mid_valid),
        .in_ready       (mid_ready),
        .in_info        (mid_info),
        .out_valid      (m_tvalid),
        .out_ready      (m_tready),
        .out_result     (res)
    );

    assign m_tdata = {6'd0,
                      res.reserved_flag,
                      res.dont_fragment,
                      res.more_fragments,
                      res.frag_ofs,
                      res.is_fragment,
                      res.hand_to_next_layer,
                      res.next_protocol,
                      res.payload_len,
                      res.header_len,
                      res.warning_flags,
                      res.raise_error_event,
                      res.status};

endmodule
`default_nettype wire

// ===== rtl/ihc_parse.sv =====
`default_nettype none
module ihc_parse (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire logic [7:0]        data_byte,
    input  wire logic              first_byte,
    input  wire logic [15:0]       captured_length,
    input  wire logic              after_ip_layer,
    input  wire logic              already_tunneled,
    input  wire logic              unsure_encap,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output ihc_pkg::hdr_info_t     out_info
);
    import ihc_pkg::*;

    logic [5:0]  pos_reg, pos_next;
    logic        ignore_reg, ignore_next;
    logic [20:0] sum_reg, sum_next;
    logic [7:0]  hi_reg, hi_next;
    logic [5:0]  hdr_reg, hdr_next;
    logic [15:0] tot_reg, tot_next;
    logic [15:0] cap_reg, cap_next;
    logic [15:0] frag_reg, frag_next;
    logic [7:0]  proto_reg, proto_next;
    logic [31:0] src_reg, src_next;
    logic [31:0] dst_reg, dst_next;
    logic        out_valid_reg, out_valid_next;
    hdr_info_t   info_reg, info_next;

    logic        in_fire, active, reject, last_byte, load;
    status_t     rej_status;
    logic        rej_event;
    logic [5:0]  pos;
    logic [20:0] sum_c;
    logic [7:0]  hi_c;
    logic [5:0]  hdr_c;
    logic [15:0] tot_c, frag_c;
    logic [7:0]  proto_c;
    logic [31:0] src_c, dst_c;

    assign in_ready  = !out_valid_reg || out_ready;
    assign in_fire   = in_valid && in_ready;
    assign active    = in_fire && (first_byte || !ignore_reg);
    assign out_valid = out_valid_reg;
    assign out_info  = info_reg;

    always_comb begin
        pos     = first_byte ? '0 : pos_reg;
        sum_c   = first_byte ? '0 : sum_reg;
        hi_c    = first_byte ? '0 : hi_reg;
        hdr_c   = first_byte ? '0 : hdr_reg;
        tot_c   = first_byte ? '0 : tot_reg;
        frag_c  = first_byte ? '0 : frag_reg;
        proto_c = first_byte ? '0 : proto_reg;
        src_c   = first_byte ? '0 : src_reg;
        dst_c   = first_byte ? '0 : dst_reg;

        cap_next   = first_byte ? captured_length : cap_reg;
        hdr_next   = hdr_c;
        hi_next    = hi_c;
        sum_next   = sum_c;
        tot_next   = tot_c;
        frag_next  = frag_c;
        proto_next = proto_c;
        src_next   = src_c;
        dst_next   = dst_c;
        reject     = 1'b0;
        rej_status = ST_OK;
        rej_event  = 1'b0;

        if (pos == POS_VER_IHL) begin
            hdr_next = {data_byte[3:0], 2'b00};
            if (cap_next < MIN_HDR_BYTES) begin
                reject     = 1'b1;
                rej_status = ST_TRUNCATED;
                rej_event  = !unsure_encap;
            end else if (after_ip_layer && already_tunneled) begin
                reject     = 1'b1;
                rej_status = ST_MULTI_ENCAP;
                rej_event  = 1'b1;
            end else if (data_byte[7:4] != IP_VERSION4) begin
                reject     = 1'b1;
                rej_status = ST_NOT_IPV4;
                rej_event  = !unsure_encap;
            end else if ({10'd0, hdr_next} < MIN_HDR_BYTES) begin
                reject     = 1'b1;
                rej_status = ST_BAD_HLEN;
                rej_event  = 1'b1;
            end
        end

        if (!pos[0]) begin
            hi_next = data_byte;
        end else begin
            sum_next = sum_c + {5'd0, hi_c, data_byte};
        end

        case (pos)
            POS_TOTLEN_H: tot_next   = {data_byte, 8'd0};
            POS_TOTLEN_L: tot_next   = {tot_c[15:8], data_byte};
            POS_FRAG_H:   frag_next  = {data_byte, 8'd0};
            POS_FRAG_L:   frag_next  = {frag_c[15:8], data_byte};
            POS_PROTO:    proto_next = data_byte;
            POS_SRC_0, POS_SRC_1, POS_SRC_2, POS_SRC_3:
                src_next = {src_c[23:0], data_byte};
            POS_DST_0, POS_DST_1, POS_DST_2, POS_DST_3:
                dst_next = {dst_c[23:0], data_byte};
            default: ;
        endcase

        if (pos == POS_TOTLEN_L) begin
            if (tot_next > cap_next) begin
                reject     = 1'b1;
                rej_status = ST_LEN_OVER_CAP;
                rej_event  = 1'b1;
            end else if (tot_next < {10'd0, hdr_next}) begin
                reject     = 1'b1;
                rej_status = ST_LEN_UNDER_HLEN;
                rej_event  = 1'b1;
            end
        end

        last_byte = !reject && (({1'b0, pos} + 7'd1) == {1'b0, hdr_next});
        load      = active && (reject || last_byte);

        ignore_next = ignore_reg;
        pos_next    = pos_reg;
        if (active) begin
            ignore_next = reject || last_byte;
            pos_next    = last_byte ? '0 : pos + 6'd1;
        end

        info_next.status      = reject ? rej_status : ST_OK;
        info_next.raise_event = reject && rej_event;
        info_next.hdr_bytes   = hdr_next;
        info_next.total_len   = tot_next;
        info_next.frag_word   = frag_next;
        info_next.proto       = proto_next;
        info_next.src_addr    = src_next;
        info_next.dst_addr    = dst_next;
        info_next.sum         = sum_next;

        out_valid_next = load || (out_valid_reg && !out_ready);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg       <= '0;
            ignore_reg    <= 1'b1;
            out_valid_reg <= 1'b0;
        end else begin
            pos_reg       <= pos_next;
            ignore_reg    <= ignore_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (active) begin
            sum_reg   <= sum_next;
            hi_reg    <= hi_next;
            hdr_reg   <= hdr_next;
            tot_reg   <= tot_next;
            cap_reg   <= cap_next;
            frag_reg  <= frag_next;
            proto_reg <= proto_next;
            src_reg   <= src_next;
            dst_reg   <= dst_next;
        end
        if (load) begin
            info_reg <= info_next;
        end
    end

endmodule
`default_nettype wire

// ===== rtl/ihc_check.sv =====
`default_nettype none
module ihc_check (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               check_checksum,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire ihc_pkg::hdr_info_t in_info,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output ihc_pkg::result_t        out_result
);
    import ihc_pkg::*;

    logic        out_valid_reg, out_valid_next;
    result_t     result_reg, result_next;
    logic        load;
    logic [12:0] off;
    logic        rf, df, mf, frag, ok;
    logic [15:0] payload;
    logic [16:0] fold1, fold2, len_sum;
    logic [7:0]  ms, md;
    logic [13:0] w;

    assign in_ready   = !out_valid_reg || out_ready;
    assign load       = in_valid && in_ready;
    assign out_valid  = out_valid_reg;
    assign out_result = result_reg;

    always_comb begin
        ok      = (in_info.status == ST_OK);
        off     = in_info.frag_word[12:0];
        rf      = in_info.frag_word[15];
        df      = in_info.frag_word[14];
        mf      = in_info.frag_word[13];
        payload = in_info.total_len - {10'd0, in_info.hdr_bytes};
        ms      = in_info.src_addr[31:24];
        md      = in_info.dst_addr[31:24];
        fold1   = {12'd0, in_info.sum[20:16]} + {1'b0, in_info.sum[15:0]};
        fold2   = fold1 + {16'd0, fold1[16]};
        len_sum = {4'd0, off} + {1'b0, in_info.total_len};
        frag    = ((off != '0) || mf) && (payload != '0);

        w                = '0;
        w[W_SAME_ADDR]   = in_info.src_addr == in_info.dst_addr;
        w[W_SRC_BCAST]   = &in_info.src_addr;
        w[W_DST_BCAST]   = &in_info.dst_addr;
        w[W_LOOPBACK]    = (ms == 8'h7F) || (md == 8'h7F);
        w[W_SRC_THISNET] = ms == 8'h00;
        w[W_DST_THISNET] = md == 8'h00;
        w[W_SRC_MCAST]   = ms[7:4] == 4'hE;
        w[W_SRC_RSVD]    = ms[7:4] == 4'hF;
        w[W_DST_RSVD]    = md[7:4] == 4'hF;
        w[W_DF_OFFSET]   = df && (off != '0);
        w[W_LEN_OFFSET]  = len_sum[16];
        w[W_ZERO_FRAG]   = ((off != '0) || mf) && (payload == '0);
        w[W_BAD_FRAGBIT] = mf && df;
        w[W_BAD_CSUM]    = check_checksum && (fold2[15:0] != 16'hFFFF);

        result_next                    = '0;
        result_next.status             = in_info.status;
        result_next.raise_error_event  = in_info.raise_event;
        if (ok) begin
            result_next.warning_flags      = w;
            result_next.header_len         = in_info.hdr_bytes;
            result_next.payload_len        = payload;
            result_next.next_protocol      = in_info.proto;
            result_next.hand_to_next_layer = !frag || ((off == '0) && (in_info.proto == PROTO_UDP));
            result_next.is_fragment        = frag;
            result_next.frag_ofs           = off;
            result_next.more_fragments     = mf;
            result_next.dont_fragment      = df;
            result_next.reserved_flag      = rf;
        end

        out_valid_next = load || (out_valid_reg && !out_ready);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            result_reg <= result_next;
        end
    end

endmodule
`default_nettype wire

// ===== dv/tb.sv =====
`default_nettype none
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import ihc_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int DRAIN_CYCLES = 8;
    localparam logic [31:0] HOST_A = 32'h0A000001;
    localparam logic [31:0] HOST_B = 32'h0A000002;
    localparam logic [7:0] PROTO_TCP = 8'd6;

    typedef logic [7:0] octets_t[$];

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic cfg_wr_en = 1'b0;
    logic cfg_wr_data = 1'b0;
    logic s_tvalid = 1'b0;
    wire s_tready;
    // data_byte, captured_length, after_ip_layer, already_tunneled, unsure_encap
    logic [IN_TDATA_W-1:0] s_tdata = '0;
    // first_byte
    logic s_tuser = 1'b0;
    wire m_tvalid;
    logic m_tready = 1'b0;
    // status, raise_error_event, warning_flags, header_len, payload_len, next_protocol,
    // hand_to_next_layer, is_fragment, frag_ofs, more_fragments, dont_fragment,
    // reserved_flag
    wire [OUT_TDATA_W-1:0] m_tdata;

    ipv4_header_checker_top i_dut (
        .aclk(aclk),
        .aresetn(aresetn),
        .cfg_wr_en(cfg_wr_en),
        .cfg_wr_data(cfg_wr_data),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),
        .s_tuser(s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // header parser shadow
    logic csum_on = 1'b1;
    logic [5:0] byte_pos = '0;
    logic ignoring = 1'b1;
    logic [20:0] sum = '0;
    logic [7:0] hi_byte = '0;
    logic [5:0] hlen = '0;
    logic [15:0] tot_len = '0;
    logic [15:0] cap_len = '0;
    logic [15:0] frag_w = '0;
    logic [7:0] proto_h = '0;
    logic [31:0] src_a = '0;
    logic [31:0] dst_a = '0;

    logic [OUT_TDATA_W-1:0] verdicts_due[$];
    int src_idle_pct = 9;
    int sink_stall_pct = 70;
    int mismatches = 0;
    int cycles = 0;
    int bytes_sent = 0;
    int verdicts_made = 0;
    int verdicts_seen = 0;
    int rejections_seen = 0;

    function automatic logic [OUT_TDATA_W-1:0] pack_verdict(
        input status_t st, input logic ev, input logic [13:0] warn, input logic [5:0] hl,
        input logic [15:0] pl, input logic [7:0] pr, input logic hand, input logic frag,
        input logic [12:0] off, input logic mf, input logic df, input logic rf);
        return {6'b0, rf, df, mf, off, frag, hand, pr, pl, hl, warn, ev, st};
    endfunction

    function automatic void post_rejection(input status_t st, input logic ev);
        verdicts_due = {verdicts_due, pack_verdict(st, ev, '0, '0, '0, '0, 1'b0, 1'b0, '0,
                                                   1'b0, 1'b0, 1'b0)};
        verdicts_made++;
        ignoring = 1'b1;
    endfunction

    function automatic void take_header_byte(input logic [IN_TDATA_W-1:0] word,
                                             input logic first);
        logic [7:0] b;
        logic [5:0] pos;
        logic [31:0] c;
        logic [13:0] warn;
        logic [12:0] off;
        logic [15:0] payload;
        logic frag;
        logic hand;
        b = word[7:0];
        if (first) begin
            byte_pos = '0;
            ignoring = 1'b0;
            sum = '0;
            hi_byte = '0;
            hlen = '0;
            tot_len = '0;
            frag_w = '0;
            proto_h = '0;
            src_a = '0;
            dst_a = '0;
            cap_len = word[23:8];
        end else if (ignoring) begin
            return;
        end
        pos = byte_pos;

        if (pos == POS_VER_IHL) begin
            if (cap_len < MIN_HDR_BYTES) begin
                post_rejection(ST_TRUNCATED, !word[26]);
                return;
            end
            if (word[24] && word[25]) begin
                post_rejection(ST_MULTI_ENCAP, 1'b1);
                return;
            end
            if (b[7:4] != IP_VERSION4) begin
                post_rejection(ST_NOT_IPV4, !word[26]);
                return;
            end
            hlen = {b[3:0], 2'b00};
            if ({10'b0, hlen} < MIN_HDR_BYTES) begin
                post_rejection(ST_BAD_HLEN, 1'b1);
                return;
            end
        end

        if (!pos[0])
            hi_byte = b;
        else
            sum = sum + {5'b0, hi_byte, b};

        case (pos)
            POS_TOTLEN_H: tot_len = {b, 8'h00};
            POS_TOTLEN_L: tot_len = {tot_len[15:8], b};
            POS_FRAG_H: frag_w = {b, 8'h00};
            POS_FRAG_L: frag_w = {frag_w[15:8], b};
            POS_PROTO: proto_h = b;
            POS_SRC_0, POS_SRC_1, POS_SRC_2, POS_SRC_3: src_a = {src_a[23:0], b};
            POS_DST_0, POS_DST_1, POS_DST_2, POS_DST_3: dst_a = {dst_a[23:0], b};
            default: ;
        endcase

        if (pos == POS_TOTLEN_L) begin
            if (tot_len > cap_len) begin
                post_rejection(ST_LEN_OVER_CAP, 1'b1);
                return;
            end
            if (tot_len < {10'b0, hlen}) begin
                post_rejection(ST_LEN_UNDER_HLEN, 1'b1);
                return;
            end
        end

        if (({1'b0, pos} + 7'd1) == {1'b0, hlen}) begin
            warn = '0;
            warn[W_SAME_ADDR] = (src_a == dst_a);
            warn[W_SRC_BCAST] = (src_a == 32'hFFFFFFFF);
            warn[W_DST_BCAST] = (dst_a == 32'hFFFFFFFF);
            warn[W_LOOPBACK] = (src_a[31:24] == 8'h7F) || (dst_a[31:24] == 8'h7F);
            warn[W_SRC_THISNET] = (src_a[31:24] == 8'h00);
            warn[W_DST_THISNET] = (dst_a[31:24] == 8'h00);
            warn[W_SRC_MCAST] = (src_a[31:28] == 4'hE);
            warn[W_SRC_RSVD] = (src_a[31:28] == 4'hF);
            warn[W_DST_RSVD] = (dst_a[31:28] == 4'hF);
            off = frag_w[12:0];
            payload = tot_len - {10'b0, hlen};
            frag = 1'b0;
            if (csum_on) begin
                c = {27'b0, sum[20:16]} + {16'b0, sum[15:0]};
                c = c + (c >> 16);
                warn[W_BAD_CSUM] = (c[15:0] != 16'hFFFF);
            end
            warn[W_DF_OFFSET] = frag_w[14] && (off != 0);
            warn[W_LEN_OFFSET] = ({19'b0, off} + {16'b0, tot_len}) > 32'd65535;
            if (off != 0 || frag_w[13]) begin
                if (payload == 0)
                    warn[W_ZERO_FRAG] = 1'b1;
                else
                    frag = 1'b1;
            end
            warn[W_BAD_FRAGBIT] = frag_w[13] && frag_w[14];
            hand = !frag || (off == 0 && proto_h == PROTO_UDP);
            verdicts_due = {verdicts_due,
                            pack_verdict(ST_OK, 1'b0, warn, hlen, payload, proto_h,
                                         hand, frag, off, frag_w[13], frag_w[14],
                                         frag_w[15])};
            verdicts_made++;
            ignoring = 1'b1;
            byte_pos = '0;
            return;
        end
        byte_pos = pos + 6'd1;
    endfunction

    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (got !== want) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            mismatches++;
        end
    endfunction

    always @(posedge aclk) begin
        logic [OUT_TDATA_W-1:0] want;
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("ipv4_header_checker_top: mismatch");
            $finish;
        end else if (aresetn) begin
            if (cfg_wr_en)
                csum_on = cfg_wr_data;
            if (s_tvalid && s_tready)
                take_header_byte(s_tdata, s_tuser);
            if (m_tvalid && m_tready) begin
                verdicts_seen++;
                if (verdicts_due.size() == 0) begin
                    $error("verdict word with none expected: %h", m_tdata);
                    mismatches++;
                end else begin
                    want = verdicts_due.pop_front();
                    if (want[2:0] != ST_OK)
                        rejections_seen++;
                    check_field("status", 32'(want[2:0]), 32'(m_tdata[2:0]));
                    check_field("raise_error_event", 32'(want[3]), 32'(m_tdata[3]));
                    check_field("warning_flags", 32'(want[17:4]), 32'(m_tdata[17:4]));
                    check_field("header_len", 32'(want[23:18]), 32'(m_tdata[23:18]));
                    check_field("payload_len", 32'(want[39:24]), 32'(m_tdata[39:24]));
                    check_field("next_protocol", 32'(want[47:40]), 32'(m_tdata[47:40]));
                    check_field("hand_to_next_layer", 32'(want[48]), 32'(m_tdata[48]));
                    check_field("is_fragment", 32'(want[49]), 32'(m_tdata[49]));
                    check_field("frag_ofs", 32'(want[62:50]), 32'(m_tdata[62:50]));
                    check_field("more_fragments", 32'(want[63]), 32'(m_tdata[63]));
                    check_field("dont_fragment", 32'(want[64]), 32'(m_tdata[64]));
                    check_field("reserved_flag", 32'(want[65]), 32'(m_tdata[65]));
                    check_field("padding", 32'(want[71:66]), 32'(m_tdata[71:66]));
                end
            end
        end
        m_tready <= ($urandom_range(0, 99) >= sink_stall_pct);
    end

    task automatic send_byte(input logic [7:0] d, input logic first, input logic [15:0] cap,
                             input logic outer, input logic tun, input logic unsure);
        while ($urandom_range(0, 99) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {5'b0, unsure, tun, outer, cap, d};
        s_tuser <= first;
        do @(posedge aclk); while (!s_tready);
    endtask

    // context fields are random on every word after the first
    task automatic send_header(input octets_t h, input logic [15:0] cap, input logic outer,
                               input logic tun, input logic unsure, input int count);
        int i;
        for (i = 0; i < count; i++) begin
            if (i == 0)
                send_byte(h[0], 1'b1, cap, outer, tun, unsure);
            else
                send_byte(h[i], 1'b0, 16'($urandom), 1'($urandom), 1'($urandom),
                          1'($urandom));
            bytes_sent++;
        end
    endtask

    function automatic octets_t build_header(
        input logic [3:0] ver, input logic [3:0] ihl, input logic [15:0] tlen,
        input logic [15:0] frag, input logic [7:0] proto, input logic [31:0] src,
        input logic [31:0] dst, input logic csum_ok);
        octets_t h;
        logic [31:0] acc;
        logic [15:0] csum;
        int n;
        int i;
        n = (ihl < 5) ? 20 : ihl * 4;
        for (i = 0; i < n; i++)
            h = {h, 8'($urandom)};
        h[0] = {ver, ihl};
        h[2] = tlen[15:8];
        h[3] = tlen[7:0];
        h[6] = frag[15:8];
        h[7] = frag[7:0];
        h[9] = proto;
        h[10] = 8'h00;
        h[11] = 8'h00;
        for (i = 0; i < 4; i++) begin
            h[12 + i] = src[31 - 8 * i -: 8];
            h[16 + i] = dst[31 - 8 * i -: 8];
        end
        acc = '0;
        for (i = 0; i < n; i += 2)
            acc = acc + {16'b0, h[i], h[i + 1]};
        acc = (acc >> 16) + {16'b0, acc[15:0]};
        acc = acc + (acc >> 16);
        csum = ~acc[15:0];
        if (!csum_ok)
            csum = csum ^ 16'h0001;
        h[10] = csum[15:8];
        h[11] = csum[7:0];
        return h;
    endfunction

    task automatic send_ip_header(
        input logic [3:0] ver, input logic [3:0] ihl, input logic [15:0] tlen,
        input logic [15:0] frag, input logic [7:0] proto, input logic [31:0] src,
        input logic [31:0] dst, input logic csum_ok, input logic [15:0] cap,
        input logic outer, input logic tun, input logic unsure);
        octets_t h;
        h = build_header(ver, ihl, tlen, frag, proto, src, dst, csum_ok);
        send_header(h, cap, outer, tun, unsure, h.size());
    endtask

    task automatic idle_until_drained();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (verdicts_due.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic set_checksum_check(input logic on);
        idle_until_drained();
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= on;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    function automatic logic [31:0] pick_addr();
        logic [31:0] r;
        r = $urandom;
        case ($urandom_range(0, 7))
            0: r[31:24] = 8'h00;
            1: r[31:24] = 8'h7F;
            2: r[31:28] = 4'hE;
            3: r[31:28] = 4'hF;
            4: r = '1;
            default: ;
        endcase
        return r;
    endfunction

    function automatic logic [15:0] pick_frag();
        logic [15:0] r;
        r = 16'($urandom);
        case ($urandom_range(0, 6))
            0, 1: r = '0;
            2: r = 16'h4000;
            3: r = 16'h2000;
            4: r[15:13] = 3'b001;
            5: r[15:13] = 3'b010;
            default: ;
        endcase
        return r;
    endfunction

    task automatic random_header(input logic broken);
        logic [3:0] ver;
        logic [3:0] ihl;
        logic [15:0] tlen;
        logic [15:0] cap;
        logic [15:0] frag;
        logic [7:0] proto;
        logic [31:0] src;
        logic [31:0] dst;
        logic outer;
        logic tun;
        logic unsure;
        logic csum_ok;
        int hl;
        int pl;
        int tmp;
        int kind;
        int n;
        octets_t h;
        ver = IP_VERSION4;
        ihl = ($urandom_range(0, 3) == 0) ? 4'($urandom_range(5, 15)) : 4'd5;
        hl = ihl * 4;
        pl = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 65535 - hl)
                                          : $urandom_range(0, 64);
        tlen = 16'(hl + pl);
        case ($urandom_range(0, 2))
            0: tmp = tlen;
            1: tmp = tlen + $urandom_range(1, 200);
            default: tmp = 65535;
        endcase
        cap = (tmp > 65535) ? 16'hFFFF : 16'(tmp);
        frag = pick_frag();
        proto = ($urandom_range(0, 1) == 0) ? PROTO_UDP : 8'($urandom);
        src = pick_addr();
        dst = ($urandom_range(0, 9) == 0) ? src : pick_addr();
        outer = 1'($urandom);
        tun = outer ? 1'b0 : 1'($urandom);
        unsure = 1'($urandom);
        csum_ok = ($urandom_range(0, 99) < 85);
        kind = broken ? $urandom_range(0, 7) : -1;
        case (kind)
            0: cap = 16'($urandom_range(0, 19));
            1: begin
                outer = 1'b1;
                tun = 1'b1;
            end
            2: ver = 4'($urandom_range(5, 19));
            3: ihl = 4'($urandom_range(0, 4));
            4: begin
                tlen = 16'(hl + $urandom_range(1, 500));
                cap = 16'($urandom_range(20, tlen - 1));
            end
            5: tlen = 16'($urandom_range(0, hl - 1));
            default: ;
        endcase
        h = build_header(ver, ihl, tlen, frag, proto, src, dst, csum_ok);
        n = h.size();
        if (kind == 6)
            n = $urandom_range(1, n - 1);
        if (kind == 7) begin
            repeat ($urandom_range(1, 4))
                send_byte(8'($urandom), 1'b0, 16'($urandom), 1'($urandom), 1'($urandom),
                          1'($urandom));
        end else begin
            send_header(h, cap, outer, tun, unsure, n);
        end
    endtask

    task automatic test_idle_bytes();
        send_byte(8'h00, 1'b0, 16'hFFFF, 1'b1, 1'b1, 1'b1);
        send_byte(8'hFF, 1'b0, 16'h0000, 1'b0, 1'b0, 1'b0);
        send_byte(8'h45, 1'b0, 16'd100, 1'b0, 1'b0, 1'b0);
    endtask

    task automatic test_rejections();
        send_ip_header(IP_VERSION4, 4'd5, 16'd40, '0, PROTO_TCP, HOST_A, HOST_B, 1'b1,
                       16'd19, 1'b0, 1'b0, 1'b0);
        send_ip_header(IP_VERSION4, 4'd5, 16'd40, '0, PROTO_TCP, HOST_A, HOST_B, 1'b1,
                       16'd0, 1'b0, 1'b0, 1'b1);
        send_ip_header(IP_VERSION4, 4'd5, 16'd40, '0, PROTO_TCP, HOST_A, HOST_B, 1'b1,
                       16'd40, 1'b1, 1'b1, 1'b1);
        send_ip_header(4'd6, 4'd5, 16'd40, '0, PROTO_TCP, HOST_A, HOST_B, 1'b1,
                       16'd40, 1'b0, 1'b0, 1'b1);
        send_ip_header(4'd0, 4'd5, 16'd40, '0, PROTO_TCP, HOST_A, HOST_B, 1'b1,
                       16'd40, 1'b0, 1'b0, 1'b0);
        send_ip_header(IP_VERSION4, 4'd0, 16'd40, '0, PROTO_TCP, HOST_A, HOST_B, 1'b1,
                       16'd40, 1'b0, 1'b0, 1'b0);
        send_ip_header(IP_VERSION4, 4'd4, 16'd40, '0, PROTO_TCP, HOST_A, HOST_B, 1'b1,
                       16'd40, 1'b0, 1'b0, 1'b0);
        send_ip_header(IP_VERSION4, 4'd5, 16'd100, '0, PROTO_TCP, HOST_A, HOST_B, 1'b1,
                       16'd99, 1'b0, 1'b0, 1'b0);
        send_ip_header(IP_VERSION4, 4'd5, 16'd19, '0, PROTO_TCP, HOST_A, HOST_B, 1'b1,
                       16'd100, 1'b0, 1'b0, 1'b0);
        send_ip_header(IP_VERSION4, 4'd6, 16'd23, '0, PROTO_TCP, HOST_A, HOST_B, 1'b1,
                       16'd100, 1'b0, 1'b0, 1'b0);
    endtask

    task automatic test_lengths();
        send_ip_header(IP_VERSION4, 4'd15, 16'hFFFF, '0, PROTO_TCP, HOST_A, HOST_B, 1'b1,
                       16'hFFFF, 1'b1, 1'b0, 1'b0);
        send_ip_header(IP_VERSION4, 4'd5, 16'd20, '0, PROTO_TCP, HOST_A, HOST_B, 1'b1,
                       16'd20, 1'b0, 1'b1, 1'b0);
    endtask

    task automatic test_fragments();
        send_ip_header(IP_VERSION4, 4'd5, 16'd100, 16'h2000, PROTO_UDP, HOST_A, HOST_B,
                       1'b1, 16'd100, 1'b0, 1'b0, 1'b0);
        send_ip_header(IP_VERSION4, 4'd5, 16'd100, 16'h2000, PROTO_TCP, HOST_A, HOST_B,
                       1'b1, 16'd100, 1'b0, 1'b0, 1'b0);
        send_ip_header(IP_VERSION4, 4'd5, 16'd60000, 16'h5FFF, PROTO_TCP, HOST_A, HOST_B,
                       1'b1, 16'hFFFF, 1'b0, 1'b0, 1'b0);
        send_ip_header(IP_VERSION4, 4'd5, 16'hFFFF, 16'h0001, PROTO_UDP, HOST_A, HOST_B,
                       1'b1, 16'hFFFF, 1'b0, 1'b0, 1'b0);
        send_ip_header(IP_VERSION4, 4'd5, 16'd20, 16'h2000, PROTO_UDP, HOST_A, HOST_B,
                       1'b1, 16'd20, 1'b0, 1'b0, 1'b0);
        send_ip_header(IP_VERSION4, 4'd5, 16'd40, 16'h6000, PROTO_TCP, HOST_A, HOST_B,
                       1'b1, 16'd40, 1'b0, 1'b0, 1'b0);
        send_ip_header(IP_VERSION4, 4'd5, 16'd40, 16'h8000, PROTO_TCP, HOST_A, HOST_B,
                       1'b1, 16'd40, 1'b0, 1'b0, 1'b0);
        send_ip_header(IP_VERSION4, 4'd5, 16'd40, 16'hFFFF, PROTO_TCP, HOST_A, HOST_B,
                       1'b1, 16'd40, 1'b0, 1'b0, 1'b0);
    endtask

    task automatic test_addresses();
        send_ip_header(IP_VERSION4, 4'd5, 16'd40, '0, PROTO_TCP, 32'hFFFFFFFF,
                       32'hFFFFFFFF, 1'b1, 16'd40, 1'b0, 1'b0, 1'b0);
        send_ip_header(IP_VERSION4, 4'd5, 16'd40, '0, PROTO_TCP, 32'h7F000001,
                       32'h00000000, 1'b1, 16'd40, 1'b0, 1'b0, 1'b0);
        send_ip_header(IP_VERSION4, 4'd5, 16'd40, '0, PROTO_TCP, 32'hE0000001,
                       32'hF0000001, 1'b1, 16'd40, 1'b0, 1'b0, 1'b0);
        send_ip_header(IP_VERSION4, 4'd5, 16'd40, '0, PROTO_TCP, 32'h00000000,
                       32'h7F000001, 1'b1, 16'd40, 1'b0, 1'b0, 1'b0);
        send_ip_header(IP_VERSION4, 4'd5, 16'd40, '0, PROTO_TCP, 32'hF1234567,
                       32'hE1020304, 1'b1, 16'd40, 1'b0, 1'b0, 1'b0);
    endtask

    // a new first byte drops the header in progress
    task automatic test_abort();
        octets_t h;
        h = build_header(IP_VERSION4, 4'd5, 16'd40, '0, PROTO_UDP, HOST_A, HOST_B, 1'b1);
        send_header(h, 16'd40, 1'b0, 1'b0, 1'b0, 10);
        send_ip_header(IP_VERSION4, 4'd5, 16'd48, '0, PROTO_UDP, HOST_B, HOST_A, 1'b1,
                       16'd60, 1'b0, 1'b0, 1'b0);
    endtask

    task automatic test_checksum_switch();
        set_checksum_check(1'b1);
        send_ip_header(IP_VERSION4, 4'd5, 16'd40, '0, PROTO_TCP, HOST_A, HOST_B, 1'b0,
                       16'd40, 1'b0, 1'b0, 1'b0);
        set_checksum_check(1'b0);
        send_ip_header(IP_VERSION4, 4'd5, 16'd40, '0, PROTO_TCP, HOST_A, HOST_B, 1'b0,
                       16'd40, 1'b0, 1'b0, 1'b0);
        send_ip_header(IP_VERSION4, 4'd7, 16'd28, '0, PROTO_TCP, HOST_A, HOST_B, 1'b1,
                       16'd28, 1'b0, 1'b0, 1'b0);
        set_checksum_check(1'b1);
    endtask

    task automatic test_random_traffic(input int want_verdicts, input int want_bytes);
        int v0;
        int b0;
        v0 = verdicts_made;
        b0 = bytes_sent;
        while (verdicts_made - v0 < want_verdicts || bytes_sent - b0 < want_bytes)
            random_header($urandom_range(0, 99) < 30);
        random_header(1'b0);
    endtask

    initial begin
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_idle_bytes();
        test_rejections();
        test_lengths();
        test_fragments();
        test_addresses();
        test_abort();
        test_checksum_switch();
        test_random_traffic(1, 20);

        idle_until_drained();
        src_idle_pct = 70;
        sink_stall_pct = 9;
        set_checksum_check(1'b0);
        test_random_traffic(1, 20);

        idle_until_drained();
        src_idle_pct = 0;
        sink_stall_pct = 0;
        set_checksum_check(1'b1);
        test_random_traffic(1, 20);

        idle_until_drained();
        $display("sent %0d header bytes, checked %0d verdict words (%0d rejections)",
                 bytes_sent, verdicts_seen, rejections_seen);
        $display("covered every reject path, fragment and address warnings, checksum on/off");
        if (mismatches == 0) begin
            $display("ipv4_header_checker_top: match");
        end else begin
            $display("ipv4_header_checker_top: mismatch");
        end
        $finish;
    end
endmodule
`default_nettype wire
